### design/mlsr_pkg.sv
// shared constants and types for the multi-list swap-remove set unit
package mlsr_pkg;

	localparam int NUM_LISTS = 8;
	localparam int CAPACITY  = 1024;

	localparam int FUNC_W  = 2;
	localparam int SEL_W   = 3;
	localparam int KEY_W   = 10;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 10;
	localparam int COUNT_W = 11;

	localparam int SLOT_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int MEM_DEPTH = NUM_LISTS * CAPACITY;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_FIND   = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_MISSING = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	// flat store address of a slot in a list
	function automatic logic [ADDR_W-1:0] store_addr(input logic [SEL_W-1:0] list,
			input logic [SLOT_W-1:0] slot);
		store_addr = ADDR_W'(list) * ADDR_W'(CAPACITY) + ADDR_W'(slot);
	endfunction

endpackage

### design/multi_list_swap_remove_set_unit.sv
// multi-list unordered set with swap-remove, one shared entry memory
//
// Usage: a transaction on the input channel (in_valid/in_ready) carries func,
// list_select and entry_index; every transaction gives exactly one result on
// the output channel (out_valid/out_ready) with status, position, list_count.
// Operations: add appends at the fill count, remove swaps the last entry into
// the highest matching slot, find reports the highest matching slot, clear
// empties all lists at once.
// Timing: add, clear, operations on a list number out of range, and find or
// remove on an empty list need no scan. Find and remove otherwise scan the
// list downward from the last slot, one entry per cycle through the single
// read port of the entry memory, up to the first hit or down to slot 0.
// Flow: one transaction is worked on at a time; the next one can be taken
// the cycle after the output register loads, even while that result still
// waits for out_ready.
// Reset clears all fill counts and the control state; the entry memory is not
// cleared, as only slots below a fill count are ever read.
// When the receiver stalls, the result holds in the output register and a
// following transaction that finishes waits until that register is free.
module multi_list_swap_remove_set_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mlsr_pkg::FUNC_W-1:0]    func,
	input  logic [mlsr_pkg::SEL_W-1:0]     list_select,
	input  logic [mlsr_pkg::KEY_W-1:0]     entry_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mlsr_pkg::STAT_W-1:0]    status,
	output logic [mlsr_pkg::POS_W-1:0]     position,
	output logic [mlsr_pkg::COUNT_W-1:0]   list_count
);

	localparam int SLOT_W = mlsr_pkg::SLOT_W;
	localparam int CNT_W  = mlsr_pkg::CNT_W;
	localparam int KEY_W  = mlsr_pkg::KEY_W;
	localparam int SEL_W  = mlsr_pkg::SEL_W;
	localparam int ADDR_W = mlsr_pkg::ADDR_W;

	mlsr_pkg::state_t  state_q, state_d;
	mlsr_pkg::func_t   in_func;
	mlsr_pkg::func_t   func_q;
	logic [SEL_W-1:0]  sel_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  fill_sel_q;
	logic [SLOT_W-1:0] ptr_q;
	logic              first_s1;
	logic [KEY_W-1:0]  last_q;

	logic [CNT_W-1:0]  fill_q [mlsr_pkg::NUM_LISTS];
	logic [CNT_W-1:0]  fill_sel;
	logic [CNT_W-1:0]  fill_dec;
	logic              sel_ok;

	logic [KEY_W-1:0]  store_mem [mlsr_pkg::MEM_DEPTH];
	logic [KEY_W-1:0]  rd_data_q;
	logic              rd_en;
	logic [SLOT_W-1:0] rd_slot;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_slot;
	logic [KEY_W-1:0]  wr_data;
	logic [SEL_W-1:0]  cur_list;

	logic              accept;
	logic              add_ok;
	logic              scan_start;
	logic              hit;
	logic              miss;
	logic              rem_hit;
	logic              out_free;

	mlsr_pkg::status_t res_status_q;
	logic [SLOT_W-1:0] res_pos_q;
	logic [CNT_W-1:0]  res_count_q;

	logic              out_valid_q;
	mlsr_pkg::status_t status_q;
	logic [mlsr_pkg::POS_W-1:0]   position_q;
	logic [mlsr_pkg::COUNT_W-1:0] list_count_q;

	assign in_func  = mlsr_pkg::func_t'(func);
	assign in_ready = (state_q == mlsr_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// fill count of the list named at the input
	always_comb begin
		fill_sel = '0;
		for (int i = 0; i < mlsr_pkg::NUM_LISTS; i++) begin
			if (int'(list_select) == i) begin
				fill_sel = fill_q[i];
			end
		end
	end

	assign sel_ok     = int'(list_select) < mlsr_pkg::NUM_LISTS;
	assign fill_dec   = fill_sel - CNT_W'(1);
	assign add_ok     = accept && (in_func == mlsr_pkg::FN_ADD) && sel_ok &&
		(fill_sel < CNT_W'(mlsr_pkg::CAPACITY));
	assign scan_start = accept && sel_ok && (fill_sel != '0) &&
		((in_func == mlsr_pkg::FN_REMOVE) || (in_func == mlsr_pkg::FN_FIND));

	// rd_data_q always holds the slot ptr_q while scanning
	assign hit     = (state_q == mlsr_pkg::S_SCAN) && (rd_data_q == key_q);
	assign miss    = (state_q == mlsr_pkg::S_SCAN) && !hit && (ptr_q == '0);
	assign rem_hit = hit && (func_q == mlsr_pkg::FN_REMOVE);

	assign cur_list = (state_q == mlsr_pkg::S_IDLE) ? list_select : sel_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mlsr_pkg::S_IDLE: begin
				if (scan_start) begin
					state_d = mlsr_pkg::S_SCAN;
				end else if (accept) begin
					state_d = mlsr_pkg::S_RESP;
				end
			end
			mlsr_pkg::S_SCAN: begin
				if (hit || miss) begin
					state_d = mlsr_pkg::S_RESP;
				end
			end
			mlsr_pkg::S_RESP: begin
				if (out_free) begin
					state_d = mlsr_pkg::S_IDLE;
				end
			end
			default: state_d = mlsr_pkg::S_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		rd_en   = 1'b0;
		rd_slot = '0;
		wr_en   = 1'b0;
		wr_slot = '0;
		wr_data = '0;
		unique case (state_q)
			mlsr_pkg::S_IDLE: begin
				if (add_ok) begin
					wr_en   = 1'b1;
					wr_slot = fill_sel[SLOT_W-1:0];
					wr_data = entry_index;
				end
				if (scan_start) begin
					rd_en   = 1'b1;
					rd_slot = fill_dec[SLOT_W-1:0];
				end
			end
			mlsr_pkg::S_SCAN: begin
				if (!hit && !miss) begin
					rd_en   = 1'b1;
					rd_slot = ptr_q - SLOT_W'(1);
				end
				// swap-remove: the last entry was the first one read
				if (rem_hit) begin
					wr_en   = 1'b1;
					wr_slot = ptr_q;
					wr_data = first_s1 ? rd_data_q : last_q;
				end
			end
			mlsr_pkg::S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[mlsr_pkg::store_addr(cur_list, wr_slot)] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= store_mem[mlsr_pkg::store_addr(cur_list, rd_slot)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mlsr_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < mlsr_pkg::NUM_LISTS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == mlsr_pkg::S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			for (int i = 0; i < mlsr_pkg::NUM_LISTS; i++) begin
				if (accept && in_func == mlsr_pkg::FN_CLEAR) begin
					fill_q[i] <= '0;
				end else if (add_ok && int'(list_select) == i) begin
					fill_q[i] <= fill_q[i] + CNT_W'(1);
				end else if (rem_hit && int'(sel_q) == i) begin
					fill_q[i] <= fill_q[i] - CNT_W'(1);
				end
			end
		end
	end

	// transaction context, scan pointer and result
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= in_func;
			sel_q      <= list_select;
			key_q      <= entry_index;
			fill_sel_q <= fill_sel;
			ptr_q      <= fill_dec[SLOT_W-1:0];
			first_s1   <= 1'b1;
			res_pos_q  <= '0;
			if (in_func == mlsr_pkg::FN_CLEAR) begin
				res_status_q <= mlsr_pkg::STAT_DONE;
				res_count_q  <= '0;
			end else if (!sel_ok) begin
				res_status_q <= (in_func == mlsr_pkg::FN_ADD) ?
					mlsr_pkg::STAT_FULL : mlsr_pkg::STAT_MISSING;
				res_count_q  <= '0;
			end else if (in_func == mlsr_pkg::FN_ADD) begin
				if (add_ok) begin
					res_status_q <= mlsr_pkg::STAT_DONE;
					res_pos_q    <= fill_sel[SLOT_W-1:0];
					res_count_q  <= fill_sel + CNT_W'(1);
				end else begin
					res_status_q <= mlsr_pkg::STAT_FULL;
					res_count_q  <= fill_sel;
				end
			end else begin
				// empty list misses at once, otherwise the scan overwrites this
				res_status_q <= mlsr_pkg::STAT_MISSING;
				res_count_q  <= fill_sel;
			end
		end else if (state_q == mlsr_pkg::S_SCAN) begin
			first_s1 <= 1'b0;
			if (first_s1) begin
				last_q <= rd_data_q;
			end
			if (hit) begin
				res_status_q <= mlsr_pkg::STAT_DONE;
				res_pos_q    <= ptr_q;
				res_count_q  <= rem_hit ? (fill_sel_q - CNT_W'(1)) : fill_sel_q;
			end else if (miss) begin
				res_status_q <= mlsr_pkg::STAT_MISSING;
				res_pos_q    <= '0;
				res_count_q  <= fill_sel_q;
			end else begin
				ptr_q <= ptr_q - SLOT_W'(1);
			end
		end
		if (state_q == mlsr_pkg::S_RESP && out_free) begin
			status_q     <= res_status_q;
			position_q   <= mlsr_pkg::POS_W'(res_pos_q);
			list_count_q <= mlsr_pkg::COUNT_W'(res_count_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign position   = position_q;
	assign list_count = list_count_q;

	// scan pointer stays inside the filled part of the list
	a_ptr_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mlsr_pkg::S_SCAN |-> CNT_W'(ptr_q) < fill_sel_q)
		else $error("scan pointer beyond fill count");

	// the store is written only by an accepted add or a remove hit
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> add_ok || rem_hit)
		else $error("unexpected store write");

	// a remove hit leaves its list one shorter
	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		rem_hit |=> res_count_q == $past(fill_sel_q) - CNT_W'(1))
		else $error("remove did not shrink the list");

	// a new result enters the output register only from the response state
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !$past(out_valid_q) |-> $past(state_q) == mlsr_pkg::S_RESP)
		else $error("result loaded outside response state");

	// no transaction is taken while a list operation is in progress
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != mlsr_pkg::S_IDLE |-> !in_ready)
		else $error("input ready while busy");

endmodule
